@@ sv/ncfc_pkg.sv @@
package ncfc_pkg;

   localparam int MAX_VNS     = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int CREDIT_BITS = 16;

   localparam int VN_W    = (MAX_VNS > 1) ? $clog2(MAX_VNS) : 1;
   localparam int QI_W    = $clog2(QUEUE_DEPTH);
   localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = MAX_VNS * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int ENTRY_W = 32;
   localparam int FB_W    = 11;
   localparam int DIV_W   = 17;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int PROD_W  = CREDIT_BITS + FB_W;
   localparam int CMP_W   = 33;

   localparam int FIFO_DEPTH = 2;
   localparam int FQ_W       = $clog2(FIFO_DEPTH);
   localparam int FQC_W      = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_VN_COUNT  = 2'd0;
   localparam logic [1:0] REG_FLIT_BITS = 2'd1;
   localparam logic [1:0] REG_OUT_BUF   = 2'd2;

   localparam logic [2:0] MODE_SEND   = 3'd0;
   localparam logic [2:0] MODE_QUERY  = 3'd1;
   localparam logic [2:0] MODE_RECV   = 3'd2;
   localparam logic [2:0] MODE_CREDIT = 3'd3;
   localparam logic [2:0] MODE_PKT    = 3'd4;
   localparam logic [2:0] MODE_TICK   = 3'd5;

   localparam logic [1:0] LINK_NONE   = 2'd0;
   localparam logic [1:0] LINK_PKT    = 2'd1;
   localparam logic [1:0] LINK_CREDIT = 2'd2;

   typedef enum logic [2:0] {
      KIND_SEND, KIND_QUERY, KIND_RECV, KIND_CREDIT, KIND_PKT, KIND_TICK, KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_READ, ST_EXEC} state_type;

   typedef struct packed {
      kind_type    kind;
      logic        act;
      logic [2:0]  vn;
      logic [15:0] size_bits;
      logic [15:0] packet_tag;
      logic [15:0] arrive_flits;
      logic [15:0] credit_amount;
   } item_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] host_tag;
      logic [15:0] host_flits;
      logic [1:0]  link_kind;
      logic [2:0]  link_vn;
      logic [15:0] link_tag;
      logic [15:0] link_amount;
      logic        overflow;
   } result_type;

   typedef struct packed {
      logic [3:0]  vn_count;
      logic [10:0] flit_bits;
      logic [15:0] out_buf_flits;
      logic        load_credits;
   } cfg_type;

   function automatic logic [ADDR_W-1:0] q_addr(input logic [VN_W-1:0] vn,
                                                input logic [QI_W-1:0] idx);
      q_addr = ADDR_W'(vn * QUEUE_DEPTH + idx);
   endfunction

   function automatic logic [QI_W-1:0] q_next(input logic [QI_W-1:0] idx);
      logic [QI_W:0] s;
      s = {1'b0, idx} + 1'b1;
      q_next = (s >= (QI_W+1)'(QUEUE_DEPTH)) ? '0 : s[QI_W-1:0];
   endfunction

   function automatic logic [QI_W-1:0] q_tail(input logic [QI_W-1:0] head,
                                              input logic [QC_W-1:0] cnt);
      logic [QC_W:0] s;
      s = (QC_W+1)'(head) + (QC_W+1)'(cnt);
      if (s >= (QC_W+1)'(QUEUE_DEPTH)) begin
         s = s - (QC_W+1)'(QUEUE_DEPTH);
      end
      q_tail = s[QI_W-1:0];
   endfunction

   function automatic logic [CREDIT_BITS-1:0] sat_add(input logic [CREDIT_BITS-1:0] a,
                                                      input logic [CREDIT_BITS-1:0] b);
      logic [CREDIT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[CREDIT_BITS] ? '1 : s[CREDIT_BITS-1:0];
   endfunction

endpackage

@@ sv/ncfc_if.sv @@
interface ncfc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  vn;
   logic [15:0] size_bits;
   logic [15:0] packet_tag;
   logic [15:0] arrive_flits;
   logic [15:0] credit_amount;
   modport source (output valid, mode, vn, size_bits, packet_tag, arrive_flits,
                   credit_amount, input ready);
   modport sink (input valid, mode, vn, size_bits, packet_tag, arrive_flits,
                 credit_amount, output ready);
endinterface

interface ncfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] host_tag;
   logic [15:0] host_flits;
   logic [1:0]  link_kind;
   logic [2:0]  link_vn;
   logic [15:0] link_tag;
   logic [15:0] link_amount;
   logic        overflow;
   modport source (output valid, ok, host_tag, host_flits, link_kind, link_vn, link_tag,
                   link_amount, overflow, input ready);
   modport sink (input valid, ok, host_tag, host_flits, link_kind, link_vn, link_tag,
                 link_amount, overflow, output ready);
endinterface

@@ sv/ncfc_ram.sv @@
module ncfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/ncfc_front.sv @@
module ncfc_front (
   input  logic               clock,
   input  logic               reset,
   ncfc_req_if.sink           req_ch,
   input  logic [3:0]         vn_count,
   input  logic               q_full,
   output logic               q_push,
   output ncfc_pkg::item_type q_item
);
   import ncfc_pkg::*;

   logic [4:0] lim;
   kind_type   kind;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // Clamp the active VN count to what the hardware holds.
   assign lim = (vn_count > 4'(MAX_VNS)) ? 5'(MAX_VNS) : {1'b0, vn_count};

   always_comb begin
      case (req_ch.mode)
         MODE_SEND:   kind = KIND_SEND;
         MODE_QUERY:  kind = KIND_QUERY;
         MODE_RECV:   kind = KIND_RECV;
         MODE_CREDIT: kind = KIND_CREDIT;
         MODE_PKT:    kind = KIND_PKT;
         MODE_TICK:   kind = KIND_TICK;
         default:     kind = KIND_NOP;
      endcase
   end

   always_comb begin
      q_item.kind          = kind;
      q_item.act           = {2'b00, req_ch.vn} < lim;
      q_item.vn            = req_ch.vn;
      q_item.size_bits     = req_ch.size_bits;
      q_item.packet_tag    = req_ch.packet_tag;
      q_item.arrive_flits  = req_ch.arrive_flits;
      q_item.credit_amount = req_ch.credit_amount;
   end

   a_ready_tracks_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_ch.valid && req_ch.ready))
      else $error("push without handshake");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");
   a_act_range: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_item.act) |-> ({2'b00, q_item.vn} < 5'(MAX_VNS)))
      else $error("active VN beyond hardware");
endmodule

@@ sv/ncfc_queue.sv @@
module ncfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ncfc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ncfc_pkg::item_type head_item
);
   import ncfc_pkg::*;

   item_type         slot_ff [FIFO_DEPTH];
   logic [FQ_W-1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [FQC_W-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == FQC_W'(FIFO_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_item = slot_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == FQ_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == FQ_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue overrun");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue underrun");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FQC_W'(FIFO_DEPTH))
      else $error("queue count out of range");
endmodule

@@ sv/ncfc_back.sv @@
module ncfc_back (
   input  logic               clock,
   input  logic               reset,
   input  ncfc_pkg::cfg_type  cfg,
   input  logic               q_not_empty,
   input  ncfc_pkg::item_type q_item,
   output logic               q_pop,
   output logic               busy,
   ncfc_rsp_if.source         rsp_ch
);
   import ncfc_pkg::*;

   state_type             state_ff, state_in;
   item_type              item_ff, item_in;
   result_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CREDIT_BITS-1:0] oc_ff [MAX_VNS];
   logic [CREDIT_BITS-1:0] oc_in [MAX_VNS];
   logic [CREDIT_BITS-1:0] rc_ff [MAX_VNS];
   logic [CREDIT_BITS-1:0] rc_in [MAX_VNS];
   logic [QI_W-1:0]       oh_ff [MAX_VNS];
   logic [QI_W-1:0]       oh_in [MAX_VNS];
   logic [QC_W-1:0]       on_ff [MAX_VNS];
   logic [QC_W-1:0]       on_in [MAX_VNS];
   logic [QI_W-1:0]       ih_ff [MAX_VNS];
   logic [QI_W-1:0]       ih_in [MAX_VNS];
   logic [QC_W-1:0]       in_ff [MAX_VNS];
   logic [QC_W-1:0]       in_in [MAX_VNS];
   logic [FB_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;

   logic [FB_W-1:0]       fb;
   logic [FB_W:0]         trial;
   logic [VN_W-1:0]       vi;
   logic [ENTRY_W-1:0]    out_rd, in_rd;
   logic                  out_we, in_we, rd_en;
   logic [ADDR_W-1:0]     out_wa, in_wa, out_ra, in_ra;
   logic [ENTRY_W-1:0]    out_wd, in_wd;
   logic [PROD_W-1:0]     prod;
   logic [15:0]           ofl;

   assign fb    = (cfg.flit_bits == '0) ? FB_W'(1) : cfg.flit_bits;
   assign vi    = item_ff.vn[VN_W-1:0];
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign prod  = PROD_W'(oc_ff[vi]) * PROD_W'(fb);
   assign ofl   = out_rd[15:0];

   assign q_pop = (state_ff == ST_IDLE) && q_not_empty && !rsp_valid_ff;
   assign busy  = (state_ff != ST_IDLE) || rsp_valid_ff;

   // Next state
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = q_pop ? ((q_item.kind == KIND_SEND) ? ST_DIV : ST_READ)
                                   : ST_IDLE;
         ST_DIV:  state_in = (dcnt_ff == DCNT_W'(1)) ? ST_READ : ST_DIV;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rd_en  = state_ff == ST_READ;
   assign out_ra = q_addr(vi, oh_ff[vi]);
   assign in_ra  = q_addr(vi, ih_ff[vi]);

   // Datapath and state updates
   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      oc_in        = oc_ff;
      rc_in        = rc_ff;
      oh_in        = oh_ff;
      on_in        = on_ff;
      ih_in        = ih_ff;
      in_in        = in_ff;
      out_we       = 1'b0;
      in_we        = 1'b0;
      out_wa       = q_addr(vi, q_tail(oh_ff[vi], on_ff[vi]));
      in_wa        = q_addr(vi, q_tail(ih_ff[vi], in_ff[vi]));
      out_wd       = {item_ff.packet_tag, quo_ff[15:0]};
      in_wd        = {item_ff.packet_tag, item_ff.arrive_flits};

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               item_in = q_item;
               // Dividend rounds size up to whole flits.
               quo_in  = DIV_W'(q_item.size_bits) + DIV_W'(fb) - DIV_W'(1);
               rem_in  = '0;
               dcnt_in = DCNT_W'(DIV_W);
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, fb}) begin
               rem_in = FB_W'(trial - {1'b0, fb});
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = trial[FB_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
         end
         ST_EXEC: begin
            res_in       = '0;
            rsp_valid_in = 1'b1;
            case (item_ff.kind)
               KIND_SEND: begin
                  if (item_ff.act && (CMP_W'(oc_ff[vi]) >= CMP_W'(quo_ff))
                      && (on_ff[vi] < QC_W'(QUEUE_DEPTH))) begin
                     out_we    = 1'b1;
                     on_in[vi] = on_ff[vi] + 1'b1;
                     oc_in[vi] = CREDIT_BITS'(CMP_W'(oc_ff[vi]) - CMP_W'(quo_ff));
                     res_in.ok = 1'b1;
                  end
               end
               KIND_QUERY: begin
                  res_in.ok = item_ff.act && (prod >= PROD_W'(item_ff.size_bits));
               end
               KIND_RECV: begin
                  if (item_ff.act && (in_ff[vi] != '0)) begin
                     ih_in[vi]          = q_next(ih_ff[vi]);
                     in_in[vi]          = in_ff[vi] - 1'b1;
                     res_in.ok          = 1'b1;
                     res_in.host_tag    = in_rd[31:16];
                     res_in.host_flits  = in_rd[15:0];
                     res_in.link_kind   = LINK_CREDIT;
                     res_in.link_vn     = item_ff.vn;
                     res_in.link_amount = in_rd[15:0];
                  end
               end
               KIND_CREDIT: begin
                  if (item_ff.act) begin
                     rc_in[vi] = sat_add(rc_ff[vi], CREDIT_BITS'(item_ff.credit_amount));
                  end
               end
               KIND_PKT: begin
                  if (!item_ff.act || (in_ff[vi] >= QC_W'(QUEUE_DEPTH))) begin
                     res_in.overflow = 1'b1;
                  end else begin
                     in_we     = 1'b1;
                     in_in[vi] = in_ff[vi] + 1'b1;
                  end
               end
               KIND_TICK: begin
                  if (item_ff.act && (on_ff[vi] != '0)
                      && (CMP_W'(rc_ff[vi]) >= CMP_W'(ofl))) begin
                     oh_in[vi]          = q_next(oh_ff[vi]);
                     on_in[vi]          = on_ff[vi] - 1'b1;
                     rc_in[vi]          = CREDIT_BITS'(CMP_W'(rc_ff[vi]) - CMP_W'(ofl));
                     oc_in[vi]          = sat_add(oc_ff[vi], CREDIT_BITS'(ofl));
                     res_in.ok          = 1'b1;
                     res_in.link_kind   = LINK_PKT;
                     res_in.link_vn     = item_ff.vn;
                     res_in.link_tag    = out_rd[31:16];
                     res_in.link_amount = ofl;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      if (cfg.load_credits) begin
         for (int i = 0; i < MAX_VNS; i++) begin
            oc_in[i] = CREDIT_BITS'(cfg.out_buf_flits);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_VNS; i++) begin
            oc_ff[i] <= CREDIT_BITS'(16);
            rc_ff[i] <= '0;
            oh_ff[i] <= '0;
            on_ff[i] <= '0;
            ih_ff[i] <= '0;
            in_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         oc_ff        <= oc_in;
         rc_ff        <= rc_in;
         oh_ff        <= oh_in;
         on_ff        <= on_in;
         ih_ff        <= ih_in;
         in_ff        <= in_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
   end

   ncfc_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_out_store (
      .clock(clock), .wr_en(out_we), .wr_addr(out_wa), .wr_data(out_wd),
      .rd_en(rd_en), .rd_addr(out_ra), .rd_data(out_rd));

   ncfc_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_in_store (
      .clock(clock), .wr_en(in_we), .wr_addr(in_wa), .wr_data(in_wd),
      .rd_en(rd_en), .rd_addr(in_ra), .rd_data(in_rd));

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = res_ff.ok;
   assign rsp_ch.host_tag    = res_ff.host_tag;
   assign rsp_ch.host_flits  = res_ff.host_flits;
   assign rsp_ch.link_kind   = res_ff.link_kind;
   assign rsp_ch.link_vn     = res_ff.link_vn;
   assign rsp_ch.link_tag    = res_ff.link_tag;
   assign rsp_ch.link_amount = res_ff.link_amount;
   assign rsp_ch.overflow    = res_ff.overflow;

   a_pkt_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (res_ff.link_kind == LINK_PKT)) |-> res_ff.ok)
      else $error("packet to router without ok");
   a_ovf_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.overflow) |-> !res_ff.ok)
      else $error("overflow with ok");
   a_held_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("back end ran with result pending");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff != '0))
      else $error("divider count underflow");
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      on_ff[vi] <= QC_W'(QUEUE_DEPTH) && in_ff[vi] <= QC_W'(QUEUE_DEPTH))
      else $error("VN queue count out of range");
endmodule

@@ sv/noc_endpoint_credit_flow_control.sv @@
// Network endpoint with credit-based flow control per virtual network (VN).
// req_ch carries one transaction per event: host send, space query, host
// receive, router credit grant, router packet arrival or output tick. rsp_ch
// returns exactly one result transaction per request, in order.
// The csr_ APB-style port holds vn_count (0x0), flit_bits (0x4) and
// out_buf_flits (0x8); writing out_buf_flits reloads every output credit
// counter. Write configuration only while the block is idle.
// A send passes through a 17-step restoring divider that rounds bits up to
// flits, then a store read and an execute step; every other transaction
// goes through the store read and execute only. One transaction is worked on
// at a time and the next is not started until the result has been taken.
// A two-entry request queue keeps accepting while a result waits.
// Reset (synchronous, active high) empties all queues, zeroes router credits,
// loads each output credit counter with 16 and restores register defaults.
// Queue stores come up unwritten and need no clearing pass.
// When the receiver stalls rsp_ch, the result holds, the back end waits,
// and req_ch.ready drops once the request queue is full.
module noc_endpoint_credit_flow_control (
   input  logic                         clock,
   input  logic                         reset,
   ncfc_req_if.sink                     req_ch,
   ncfc_rsp_if.source                   rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ncfc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import ncfc_pkg::*;

   logic [3:0]  vn_count_ff, vn_count_in;
   logic [10:0] flit_bits_ff, flit_bits_in;
   logic [15:0] out_buf_ff, out_buf_in;
   logic        wr;
   logic [1:0]  ridx;
   cfg_type     cfg;
   logic        q_push, q_full, q_pop, q_not_empty, busy;
   item_type    push_item, head_item;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign ridx       = csr_paddr[3:2];

   // Decode register writes; unmapped offsets are dropped.
   always_comb begin
      vn_count_in  = vn_count_ff;
      flit_bits_in = flit_bits_ff;
      out_buf_in   = out_buf_ff;
      if (wr) begin
         case (ridx)
            REG_VN_COUNT:  vn_count_in  = csr_pwdata[3:0];
            REG_FLIT_BITS: flit_bits_in = csr_pwdata[10:0];
            REG_OUT_BUF:   out_buf_in   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_VN_COUNT:  csr_prdata = {28'd0, vn_count_ff};
         REG_FLIT_BITS: csr_prdata = {21'd0, flit_bits_ff};
         REG_OUT_BUF:   csr_prdata = {16'd0, out_buf_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_count_ff  <= 4'd1;
         flit_bits_ff <= 11'd64;
         out_buf_ff   <= 16'd16;
      end else begin
         vn_count_ff  <= vn_count_in;
         flit_bits_ff <= flit_bits_in;
         out_buf_ff   <= out_buf_in;
      end
   end

   // Reload output credits with the value being written.
   always_comb begin
      cfg.vn_count      = vn_count_ff;
      cfg.flit_bits     = flit_bits_ff;
      cfg.out_buf_flits = csr_pwdata[15:0];
      cfg.load_credits  = wr && (ridx == REG_OUT_BUF);
   end

   ncfc_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .vn_count(vn_count_ff),
      .q_full(q_full), .q_push(q_push), .q_item(push_item));

   ncfc_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(push_item),
      .full(q_full), .pop(q_pop), .not_empty(q_not_empty), .head_item(head_item));

   ncfc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_not_empty(q_not_empty),
      .q_item(head_item), .q_pop(q_pop), .busy(busy), .rsp_ch(rsp_ch));

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      cfg.load_credits |-> (!busy && !q_not_empty))
      else $error("credit reload while busy");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty request queue");
   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(busy))
      else $error("result without work");
endmodule
